// ----- sv/assert_macros.svh -----
// Assertion macros shared by the list modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

// ----- sv/isl_pkg.sv -----
// Package with types and constants of the indexed sequence list.
package isl_pkg;
   localparam int Capacity = 64;
   localparam int SlotW = $clog2(Capacity);
   localparam int CountW = 7;

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_READ      = 3'd2,
      OP_DELETE    = 3'd3,
      OP_CLEAR     = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_FIND, S_WALK, S_RDVAL, S_LINK, S_DELRD, S_DELFIX, S_DONE
   } state_type;

   typedef struct packed {
      logic load;       // capture request word
      logic find;       // take free slot, write new entry
      logic walk_start; // begin walk at first slot
      logic walk_step;  // follow next link
      logic rd_value;   // register value at current slot
      logic link;       // relink for insert
      logic del_read;   // register prev and next of current slot
      logic del_fix;    // relink around current slot
      logic clear;      // drop all entries
      logic finish;     // load response register
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic full;
      logic bad_pos;
      logic walk_done;
   } sts_type;
endpackage

// ----- sv/isl_ctrl.sv -----
// Controller state machine of the indexed sequence list.
`include "assert_macros.svh"
module isl_ctrl
   import isl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid && req_ready) state_in = S_FIND;
         S_FIND: begin
            case (sts.op)
               OP_INS_FRONT, OP_INS_BACK: state_in = sts.full ? S_DONE : S_LINK;
               OP_READ, OP_DELETE: state_in = sts.bad_pos ? S_DONE : S_WALK;
               default: state_in = S_DONE;
            endcase
         end
         S_WALK: if (sts.walk_done)
            state_in = (sts.op == OP_READ) ? S_RDVAL : S_DELRD;
         S_RDVAL: state_in = S_DONE;
         S_LINK: state_in = S_DONE;
         S_DELRD: state_in = S_DELFIX;
         S_DELFIX: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: cmd.load = req_valid && req_ready;
         S_FIND: begin
            cmd.walk_start = 1'b1;
            cmd.find = (sts.op == OP_INS_FRONT || sts.op == OP_INS_BACK) && !sts.full;
            cmd.clear = (sts.op == OP_CLEAR);
         end
         S_WALK: cmd.walk_step = !sts.walk_done;
         S_RDVAL: cmd.rd_value = 1'b1;
         S_LINK: cmd.link = 1'b1;
         S_DELRD: cmd.del_read = 1'b1;
         S_DELFIX: cmd.del_fix = 1'b1;
         S_DONE: cmd.finish = 1'b1;
         default: cmd = '0;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_NEXT(a_done_gives_rsp, clock, reset, state_ff == S_DONE, rsp_valid_ff)
   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, cmd.finish, !rsp_valid_ff || rsp_ready)
   `ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == S_FIND)
endmodule

// ----- sv/isl_data.sv -----
// Datapath of the indexed sequence list: slot store, links and counters.
`include "assert_macros.svh"
module isl_data
   import isl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_value,
   input  logic [6:0]         req_position,
   output logic signed [31:0] rsp_read_value,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_length
);
   logic [31:0] values_mem [Capacity];
   logic [SlotW-1:0] next_mem [Capacity];
   logic [SlotW-1:0] prev_mem [Capacity];

   logic [2:0] op_ff;
   logic [31:0] val_ff;
   logic [6:0] pos_ff;
   logic [SlotW-1:0] first_ff, last_ff, cur_ff, new_ff, p_ff, n_ff;
   logic [CountW-1:0] count_ff, idx_ff;
   logic [Capacity-1:0] free_ff;
   logic [31:0] rv_ff, rdv_ff;
   logic [1:0] st_ff;
   logic [SlotW-1:0] low_free;

   always_comb begin
      low_free = '0;
      for (int i = Capacity - 1; i >= 0; i--)
         if (free_ff[i]) low_free = SlotW'(i);
   end

   assign sts.op = op_ff;
   assign sts.full = (count_ff == CountW'(Capacity));
   assign sts.bad_pos = ({1'b0, pos_ff} >= {1'b0, count_ff});
   assign sts.walk_done = (idx_ff == pos_ff);

   always_ff @(posedge clock) begin
      if (cmd.find) begin
         values_mem[low_free] <= val_ff;
      end else if (cmd.link) begin
         if (count_ff == '0) begin
            next_mem[new_ff] <= new_ff;
            prev_mem[new_ff] <= new_ff;
         end else if (op_ff == OP_INS_FRONT) begin
            next_mem[new_ff] <= first_ff;
            prev_mem[new_ff] <= new_ff;
            prev_mem[first_ff] <= new_ff;
         end else begin
            prev_mem[new_ff] <= last_ff;
            next_mem[new_ff] <= new_ff;
            next_mem[last_ff] <= new_ff;
         end
      end else if (cmd.del_fix) begin
         if (count_ff != CountW'(1)) begin
            if (pos_ff == 7'd0) prev_mem[n_ff] <= n_ff;
            else if (pos_ff == count_ff - 1'b1) next_mem[p_ff] <= p_ff;
            else begin
               next_mem[p_ff] <= n_ff;
               prev_mem[n_ff] <= p_ff;
            end
         end
      end
      rdv_ff <= values_mem[cur_ff];
      p_ff <= prev_mem[cur_ff];
      n_ff <= next_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_operation;
         val_ff <= req_value;
         pos_ff <= req_position;
      end
      if (cmd.find) new_ff <= low_free;
      if (cmd.walk_start) begin
         cur_ff <= first_ff;
         idx_ff <= '0;
      end else if (cmd.walk_step) begin
         cur_ff <= next_mem[cur_ff];
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.load) rv_ff <= '0;
      else if (cmd.walk_start && op_ff == OP_READ && sts.bad_pos) rv_ff <= '1;
      else if (cmd.rd_value) rv_ff <= rdv_ff;
      if (cmd.finish) begin
         rsp_read_value <= rv_ff;
         rsp_status <= st_ff;
         rsp_length <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         last_ff <= '0;
         count_ff <= '0;
         free_ff <= '1;
         st_ff <= ST_OK;
      end else begin
         if (cmd.load) st_ff <= ST_OK;
         if (cmd.walk_start) begin
            if ((op_ff == OP_INS_FRONT || op_ff == OP_INS_BACK) && sts.full) begin
               st_ff <= ST_FULL;
            end else if ((op_ff == OP_READ || op_ff == OP_DELETE) && sts.bad_pos) begin
               st_ff <= ST_BAD_INDEX;
            end
         end
         if (cmd.find) free_ff[low_free] <= 1'b0;
         if (cmd.link) begin
            if (count_ff == '0) begin
               first_ff <= new_ff;
               last_ff <= new_ff;
            end else if (op_ff == OP_INS_FRONT) first_ff <= new_ff;
            else last_ff <= new_ff;
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.del_fix) begin
            if (count_ff == CountW'(1)) begin
               first_ff <= '0;
               last_ff <= '0;
            end else if (pos_ff == 7'd0) first_ff <= n_ff;
            else if (pos_ff == count_ff - 1'b1) last_ff <= p_ff;
            free_ff[cur_ff] <= 1'b1;
            count_ff <= count_ff - 1'b1;
         end
         if (cmd.clear) begin
            free_ff <= '1;
            first_ff <= '0;
            last_ff <= '0;
            count_ff <= '0;
         end
      end
   end

   `ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1, count_ff <= CountW'(Capacity))
   `ASSERT_IMPLIES(a_free_matches, clock, reset, !cmd.link, $countones(free_ff) + int'(count_ff) == Capacity)
   `ASSERT_IMPLIES(a_find_has_slot, clock, reset, cmd.find, free_ff != '0)
endmodule

// ----- sv/indexed_sequence_list.sv -----
// Top level of the indexed sequence list: controller and datapath.
//  channel  direction  words
//  req_     in         operation, value, position
//  rsp_     out        read_value, status, length
// An insert steps through find, link and done; a clear, a refused insert,
// a bad position or an unused code through find and done. A read or delete
// walks next links, one link per cycle, then reads the value or relinks.
// Reset is synchronous and empties the list at once.
// A stalled response holds the block in idle until it is taken.
module indexed_sequence_list
   import isl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_value,
   input  logic [6:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_read_value,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_length
);
   cmd_type cmd;
   sts_type sts;

   isl_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   isl_data u_data (
      .clock, .reset, .cmd, .sts, .req_operation, .req_value, .req_position,
      .rsp_read_value, .rsp_status, .rsp_length
   );
endmodule

// ----- sim/indexed_sequence_list_test.sv -----
// Testbench for the indexed sequence list: random and directed list operations.
`timescale 1ns / 1ps
module indexed_sequence_list_test
   import isl_pkg::*;
;

   class list_scoreboard;
      logic signed [31:0] contents[$];
      logic signed [31:0] want_value[$];
      logic [1:0]         want_status[$];
      logic [6:0]         want_length[$];
      int                 errors;
      int                 checked;

      function void note_word(logic [2:0] op, logic signed [31:0] val, logic [6:0] pos);
         logic signed [31:0] rv;
         logic [1:0]         st;
         rv = 0;
         st = ST_OK;
         case (op)
            OP_INS_FRONT, OP_INS_BACK: begin
               if (contents.size() >= Capacity) st = ST_FULL;
               else if (op == OP_INS_FRONT) contents.push_front(val);
               else contents.push_back(val);
            end
            OP_READ: begin
               if (pos >= contents.size()) begin
                  st = ST_BAD_INDEX;
                  rv = -1;
               end else rv = contents[pos];
            end
            OP_DELETE: begin
               if (pos >= contents.size()) st = ST_BAD_INDEX;
               else contents.delete(pos);
            end
            OP_CLEAR: contents.delete();
            default: ;
         endcase
         want_value.push_back(rv);
         want_status.push_back(st);
         want_length.push_back(7'(contents.size()));
      endfunction

      function int pending();
         return want_value.size();
      endfunction

      task check_word(logic signed [31:0] rv, logic [1:0] st, logic [6:0] len);
         logic signed [31:0] ev;
         logic [1:0]         es;
         logic [6:0]         el;
         if (want_value.size() == 0) begin
            report("response word with nothing expected");
            return;
         end
         ev = want_value.pop_front();
         es = want_status.pop_front();
         el = want_length.pop_front();
         checked++;
         if (rv !== ev) report($sformatf("read_value %0d, want %0d", rv, ev));
         if (st !== es) report($sformatf("status %0d, want %0d", st, es));
         if (len !== el) report($sformatf("length %0d, want %0d", len, el));
      endtask

      task report(string msg);
         errors++;
         if (errors <= 50) $display("mismatch at %0t: %s", $realtime, msg);
      endtask
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [2:0]         req_operation = 0;
   logic signed [31:0] req_value = 0;
   logic [6:0]         req_position = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [31:0] rsp_read_value;
   logic [1:0]         rsp_status;
   logic [6:0]         rsp_length;

   list_scoreboard board = new();
   int  hold_off = 0;
   bit  stimulus_done = 0;
   int  full_hits = 0;
   int  bad_hits = 0;

   indexed_sequence_list u_top (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   function int gap_length();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
      return $urandom_range(0, 3);
   endfunction

   task send_word(logic [2:0] op, logic signed [31:0] val, logic [6:0] pos);
      req_valid     <= 1;
      req_operation <= op;
      req_value     <= val;
      req_position  <= pos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_word(op, val, pos);
      if (board.want_status[$] == ST_FULL) full_hits++;
      if (board.want_status[$] == ST_BAD_INDEX) bad_hits++;
   endtask

   task idle_gap(int n);
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task send_random(int fill_bias);
      int                 r;
      int                 len;
      logic [2:0]         op;
      logic signed [31:0] val;
      logic [6:0]         pos;
      r   = $urandom_range(0, 99);
      len = board.contents.size();
      val = $urandom;
      if (r < fill_bias) op = 3'($urandom_range(0, 1));
      else if (r < 70) op = OP_READ;
      else if (r < 95) op = OP_DELETE;
      else if (r < 98) op = OP_CLEAR;
      else op = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 9) == 0 || len == 0) pos = 7'($urandom);
      else if ($urandom_range(0, 3) == 0) pos = $urandom_range(0, 7) < len ?
         7'($urandom_range(0, 7)) : 7'd0;
      else pos = 7'($urandom_range(0, len - 1));
      send_word(op, val, pos);
   endtask

   task wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_word(OP_READ, 0, 0);
      send_word(OP_DELETE, 0, 0);
      send_word(OP_CLEAR, 0, 0);
      send_word(OP_INS_BACK, 32'sh7fffffff, 0);
      send_word(OP_INS_FRONT, 32'sh80000000, 0);
      send_word(OP_INS_BACK, -1, 0);
      send_word(OP_INS_FRONT, 0, 0);
      send_word(OP_READ, 0, 0);
      send_word(OP_READ, 0, 3);
      send_word(OP_READ, 0, 4);
      send_word(OP_READ, 0, 127);
      send_word(OP_DELETE, 0, 127);
      send_word(3'd5, 32'sh55555555, 7'h55);
      send_word(3'd7, 32'shaaaaaaaa, 7'h2a);
      send_word(OP_DELETE, 0, 1);
      send_word(OP_DELETE, 0, 2);
      send_word(OP_DELETE, 0, 0);
      send_word(OP_READ, 0, 0);
      send_word(OP_CLEAR, 0, 0);
      for (int i = 0; i < 66; i++) send_word(3'(i % 2), $urandom, 0);
      send_word(OP_READ, 0, 63);
      send_word(OP_DELETE, 0, 63);
      send_word(OP_DELETE, 0, 0);
      send_word(OP_DELETE, 0, 30);
      send_word(OP_READ, 0, 61);
      send_word(OP_CLEAR, 0, 0);
      wait_drained();
      for (int i = 0; i < 1100; i++) begin
         if (i == 300) begin
            hold_off = 400;
            repeat (4) send_word(OP_INS_BACK, $urandom, 0);
         end
         if (i == 600) wait_drained();
         if (i % 250 < 60) send_random(60);
         else send_random(25);
         idle_gap(gap_length());
      end
      wait_drained();
      repeat (200) @(posedge clock);
      stimulus_done = 1;
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_off > 0) begin
         hold_off  <= hold_off - 1;
         rsp_ready <= 0;
      end else rsp_ready <= ($urandom_range(0, 3) != 0) ||
         ($urandom_range(0, 9) == 0 && gap_length() == 0);
      if (!reset && rsp_valid && rsp_ready)
         board.check_word(rsp_read_value, rsp_status, rsp_length);
   end

   initial begin
      wait (stimulus_done);
      $display("checked %0d response words, %0d full refusals, %0d bad positions",
         board.checked, full_hits, bad_hits);
      if (board.errors == 0 && board.pending() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
